[hw/rtl/tli_pkg.sv]
package tli_pkg;

   localparam int TableDepth = 256;
   localparam int IdxW = $clog2(TableDepth);
   localparam int CntW = IdxW + 1;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_RANGE  = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;
   localparam logic [1:0] ST_EMPTY  = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ENDS_RD,
      S_ENDS_CHK,
      S_MID_RD,
      S_MID_CHK,
      S_SEG_RD,
      S_SEG_CHK,
      S_DIV,
      S_MUL,
      S_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

endpackage

[hw/rtl/tli_divider.sv]
// Restoring divider: quotient = num / den, num and den non-negative,
// one quotient bit per cycle. Quotient saturated to 17 bits (0..65536).
module tli_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [49:0] num,
   input  logic [32:0] den,
   output tli_pkg::div_ctl_type ctl,
   output logic [16:0] quot
);
   import tli_pkg::*;

   logic [49:0] rem_ff, rem_in;
   logic [32:0] den_ff, den_in;
   logic [17:0] q_ff, q_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [50:0] trial;

   // Long division restricted to 18 quotient bits: high quotient bits
   // beyond that saturate (clamped to 65536 anyway).
   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         rem_in  = num;
         den_in  = den;
         q_in    = '0;
         cnt_in  = 6'd17;
         busy_in = 1'b1;
         // saturate when num >= den<<18
         if ((num >> 18) >= {17'd0, den}) begin
            q_in    = '1;
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (busy_ff) begin
         trial = {1'b0, rem_ff} - ({18'd0, den_ff} << cnt_ff);
         if (!trial[50]) begin
            rem_in = trial[49:0];
            q_in   = q_ff | (18'd1 << cnt_ff);
         end
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign ctl  = '{start: start, busy: busy_ff, done: done_ff};
   assign quot = (q_ff > 18'd65536) ? 17'd65536 : q_ff[16:0];

endmodule

[hw/rtl/table_linear_interpolation_core.sv]
// Channel  | Handshake                | Payload
// req      | start & !busy            | req_opcode, req_entry_index, req_x_value, req_y_value
// rsp      | rsp_valid (one cycle)    | rsp_interp_value, rsp_status
// csr      | csr_valid & csr_ready    | csr_data (points_in_use, 9 bits)
//
// A write is taken only while idle. A query holds busy for the end-point reads, up to
// 8 binary-search steps at 256 points, the segment reads, the serial divider (cut short
// on saturation, skipped on a negative quotient), the multiply and posting the result.
// A range, divide or empty error ends the query early, with a zero value.
// Reset clears control state only; table contents stay undefined until written.
// Results cannot be stalled: rsp_valid lasts one cycle, as busy drops.
module table_linear_interpolation_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [7:0]  req_entry_index,
   input  logic signed [31:0] req_x_value,
   input  logic signed [31:0] req_y_value,
   output logic        rsp_valid,
   output logic signed [31:0] rsp_interp_value,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_data
);
   import tli_pkg::*;

   // table memories, one read port
   logic signed [31:0] xmem [TableDepth];
   logic signed [31:0] ymem [TableDepth];
   logic [IdxW-1:0]    rd_addr;
   logic signed [31:0] xrd_ff, yrd_ff;

   state_type state_ff, state_in;
   logic [CntW-1:0] npts_ff;
   logic [CntW-1:0] n_eff;
   logic signed [31:0] xq_ff, xq_in;
   logic signed [31:0] x0_ff, x0_in;      // first x, later x_lo
   logic signed [31:0] y0_ff, y0_in;      // later y_lo
   logic signed [31:0] xh_ff, xh_in;
   logic signed [31:0] yh_ff, yh_in;
   logic rising_ff, rising_in;
   logic [CntW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CntW-1:0] mid;
   logic sub_ff, sub_in;                   // second read of a pair; in S_DIV, divider started
   logic [16:0] delta_ff, delta_in;
   logic signed [31:0] res_ff, res_in;
   logic [1:0] st_ff, st_in;
   logic vld_ff, vld_in;

   logic        div_start;
   logic [49:0] div_num;
   logic [32:0] div_den;
   div_ctl_type div_ctl;
   logic [16:0] div_q;

   logic signed [32:0] num_s, dx_s;
   logic signed [33:0] dy;
   logic signed [51:0] prod;
   logic signed [51:0] prod_t;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign n_eff     = (npts_ff > CntW'(TableDepth)) ? CntW'(TableDepth) : npts_ff;
   assign mid       = CntW'((lo_ff + hi_ff) >> 1);

   always_ff @(posedge clock) begin
      if (start && !busy && req_opcode == OP_WRITE) begin
         xmem[req_entry_index] <= req_x_value;
         ymem[req_entry_index] <= req_y_value;
      end
      xrd_ff <= xmem[rd_addr];
      yrd_ff <= ymem[rd_addr];
   end

   tli_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .ctl   (div_ctl),
      .quot  (div_q)
   );

   // delta numerator / denominator (signs equal when in range)
   assign num_s = 33'(xh_ff) - 33'(xq_ff);
   assign dx_s  = 33'(xh_ff) - 33'(x0_ff);
   always_comb begin
      logic [32:0] an, ad;
      an = num_s[32] ? 33'(-num_s) : num_s;
      ad = dx_s[32]  ? 33'(-dx_s)  : dx_s;
      div_num = 50'({an, 16'd0});
      div_den = ad;
   end

   assign dy     = 34'(y0_ff) - 34'(yh_ff);
   assign prod   = 52'($signed({1'b0, delta_ff})) * 52'(dy);
   // divide by 65536 truncating toward zero
   assign prod_t = (prod < 0) ? -((-prod) >>> 16) : (prod >>> 16);

   always_comb begin
      state_in  = state_ff;
      xq_in     = xq_ff;
      x0_in     = x0_ff;
      y0_in     = y0_ff;
      xh_in     = xh_ff;
      yh_in     = yh_ff;
      rising_in = rising_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      sub_in    = sub_ff;
      delta_in  = delta_ff;
      res_in    = res_ff;
      st_in     = st_ff;
      vld_in    = 1'b0;
      rd_addr   = '0;
      div_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start && req_opcode == OP_QUERY) begin
               xq_in = req_x_value;
               if (n_eff == '0) begin
                  res_in = '0; st_in = ST_EMPTY; state_in = S_DONE;
               end else begin
                  lo_in = '0;
                  hi_in = n_eff - CntW'(1);
                  sub_in = 1'b0;
                  state_in = S_ENDS_RD;
               end
            end
         end
         S_ENDS_RD: begin
            // issue read of entry 0 then of entry hi
            rd_addr = sub_ff ? hi_ff[IdxW-1:0] : '0;
            state_in = S_ENDS_CHK;
         end
         S_ENDS_CHK: begin
            if (!sub_ff) begin
               x0_in = xrd_ff;
               if (hi_ff == '0) begin
                  res_in = yrd_ff; st_in = ST_OK; state_in = S_DONE;
               end else begin
                  sub_in = 1'b1; state_in = S_ENDS_RD;
               end
            end else begin
               sub_in = 1'b0;
               rising_in = x0_ff < xrd_ff;
               if ((x0_ff < xrd_ff) ? (xq_ff < x0_ff || xq_ff > xrd_ff)
                                    : (xq_ff > x0_ff || xq_ff < xrd_ff)) begin
                  res_in = '0; st_in = ST_RANGE; state_in = S_DONE;
               end else begin
                  state_in = S_MID_RD;
               end
            end
         end
         S_MID_RD: begin
            if (hi_ff - lo_ff > CntW'(1)) begin
               rd_addr = mid[IdxW-1:0];
               state_in = S_MID_CHK;
            end else begin
               rd_addr = hi_ff[IdxW-1:0];
               state_in = S_SEG_RD;
            end
         end
         S_MID_CHK: begin
            if (rising_ff ? (xq_ff < xrd_ff) : (xq_ff > xrd_ff)) hi_in = mid;
            else lo_in = mid;
            state_in = S_MID_RD;
         end
         S_SEG_RD: begin
            // hi data arrives now; read lo next
            xh_in = xrd_ff;
            yh_in = yrd_ff;
            rd_addr = IdxW'(hi_ff - CntW'(1));
            state_in = S_SEG_CHK;
         end
         S_SEG_CHK: begin
            x0_in = xrd_ff;
            y0_in = yrd_ff;
            if (xrd_ff == xh_ff) begin
               res_in = '0; st_in = ST_DIVIDE; state_in = S_DONE;
            end else begin
               state_in = S_DIV;
               sub_in = 1'b0;
            end
         end
         S_DIV: begin
            if (!sub_ff) begin
               // negative quotient clamps to zero
               if (num_s != '0 && (num_s[32] != dx_s[32])) begin
                  delta_in = '0; state_in = S_MUL;
               end else begin
                  div_start = 1'b1; sub_in = 1'b1;
               end
            end else if (div_ctl.done) begin
               delta_in = div_q; sub_in = 1'b0; state_in = S_MUL;
            end
         end
         S_MUL: begin
            res_in = 32'(52'(yh_ff) + prod_t);
            st_in = ST_OK;
            state_in = S_DONE;
         end
         S_DONE: begin
            vld_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      xq_ff <= xq_in; x0_ff <= x0_in; y0_ff <= y0_in;
      xh_ff <= xh_in; yh_ff <= yh_in; rising_ff <= rising_in;
      lo_ff <= lo_in; hi_ff <= hi_in; delta_ff <= delta_in;
      res_ff <= res_in; st_ff <= st_in;
      if (reset) begin
         state_ff <= S_IDLE;
         npts_ff  <= '0;
         vld_ff   <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         sub_ff   <= sub_in;
         if (csr_valid && csr_ready) npts_ff <= csr_data;
      end
   end

   assign rsp_valid        = vld_ff;
   assign rsp_interp_value = res_ff;
   assign rsp_status       = st_ff;

endmodule

[hw/rtl/tli_checker.sv]
module tli_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid,
   input logic signed [31:0] rsp_interp_value,
   input logic [1:0] rsp_status
);
   import tli_pkg::*;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_interp_value == '0)
      else $error("nonzero value with error status");
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("strobe longer than one cycle");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("query ended without result");
endmodule

bind table_linear_interpolation_core tli_checker u_chk (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_interp_value(rsp_interp_value),
   .rsp_status(rsp_status)
);
